// File: sv/dab_pkg.sv
package dab_pkg;

    localparam int unsigned REGION_WORDS_DEF = 1024;
    localparam logic [31:0] BASE_RESET = 32'h4400_0000;
    localparam logic [31:0] FIELD_PHYS_MASK = 32'h6007_FFFF;
    localparam logic [31:0] BIT_PHYS_MASK = 32'h600F_FFFF;

    typedef enum logic [2:0] {
        OP_ILLEGAL = 3'd0,
        OP_AND     = 3'd1,
        OP_CLR_OR  = 3'd2,
        OP_SET_XOR = 3'd3
    } op_t;

    typedef enum logic [1:0] {
        SZ_BYTE = 2'd0,
        SZ_HALF = 2'd1,
        SZ_WORD = 2'd2
    } size_t_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic        is_store;
        logic [2:0]  op;
        size_t_t     size;
        logic [4:0]  b;
        logic [4:0]  sh;
        logic [31:0] fmask;
        logic [31:0] data;
        logic        phys_hi;
        logic [17:0] word_off;
    } cmd_t;

endpackage

// File: sv/dab_ram.sv
module dab_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/dab_front.sv
module dab_front
    import dab_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        valid_in,
    input  logic        command,
    input  logic [25:0] bus_offset,
    input  logic [31:0] write_data,
    output logic        accept,
    input  logic        q_full,
    output cmd_t        cmd
);

    logic [31:0] base_reg;
    logic [31:0] d;
    logic [31:0] phys;
    logic [4:0]  w;
    logic [5:0]  wp1;
    logic [32:0] ones;
    logic [31:0] raw_mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= BASE_RESET;
        end
        else if (cfg_we)
        begin
            base_reg <= cfg_wdata;
        end
    end

    assign accept = valid_in && !q_full;

    always_comb
    begin
        d = base_reg + {6'd0, bus_offset};
        cmd.is_store = command;
        cmd.op = d[28:26];
        cmd.data = write_data;
        if (d[0])
        begin
            cmd.size = SZ_BYTE;
        end
        else if (d[1])
        begin
            cmd.size = SZ_HALF;
        end
        else
        begin
            cmd.size = SZ_WORD;
        end
        w = 5'd0;
        if (d[28])
        begin
            unique case (cmd.size)
                SZ_BYTE: cmd.b = {2'd0, d[25:23]};
                SZ_HALF: cmd.b = {1'b0, d[26:23]};
                default: cmd.b = d[27:23];
            endcase
            w = (cmd.size == SZ_BYTE) ? {2'd0, d[21:19]} : {1'b0, d[22:19]};
            phys = d & FIELD_PHYS_MASK;
        end
        else
        begin
            unique case (cmd.size)
                SZ_BYTE: cmd.b = {2'd0, d[23:21]};
                SZ_HALF: cmd.b = {1'b0, d[24:21]};
                default: cmd.b = d[25:21];
            endcase
            phys = d & BIT_PHYS_MASK;
        end
        wp1 = {1'b0, w} + 6'd1;
        ones = (33'd1 << wp1) - 33'd1;
        raw_mask = ones[31:0];
        cmd.fmask = raw_mask << cmd.b;
        unique case (cmd.size)
            SZ_BYTE: cmd.sh = {phys[1:0], 3'd0};
            SZ_HALF: cmd.sh = {phys[1], 4'd0};
            default: cmd.sh = 5'd0;
        endcase
        cmd.phys_hi = phys[30];
        cmd.word_off = phys[19:2];
    end

endmodule

// File: sv/dab_back.sv
module dab_back
    import dab_pkg::*;
#(
    parameter int unsigned REGION_WORDS = REGION_WORDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  cmd_t        q_cmd,
    output logic        q_pop,
    output logic        valid,
    input  logic        stall,
    output logic [31:0] read_data,
    output logic        bad_opcode
);

    localparam int unsigned DEPTH = 2 * REGION_WORDS;
    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned RW = $clog2(REGION_WORDS);

    state_t         state_reg, state_next;
    logic [AW-1:0]  clr_reg, clr_next;
    logic           ovalid_reg, ovalid_next;
    logic [31:0]    rdata_reg, rdata_next;
    logic           bad_reg, bad_next;
    logic [AW-1:0]  idx_reg, idx_next;
    logic [AW-1:0]  idx;
    logic           we;
    logic [AW-1:0]  waddr;
    logic [31:0]    wdata;
    logic [31:0]    word;
    logic [31:0]    smask;
    logic [31:0]    val;
    logic [31:0]    nv;
    logic [31:0]    bitm;
    logic           wr;

    assign idx = {q_cmd.phys_hi, q_cmd.word_off[RW-1:0]};

    dab_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(idx), .rdata(word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= rdata_next;
        bad_reg   <= bad_next;
        idx_reg   <= idx_next;
    end

    always_comb
    begin
        unique case (q_cmd.size)
            SZ_BYTE: smask = 32'h0000_00FF;
            SZ_HALF: smask = 32'h0000_FFFF;
            default: smask = 32'hFFFF_FFFF;
        endcase
        val = (word >> q_cmd.sh) & smask;
        bitm = 32'd1 << q_cmd.b;
        nv = val;
        wr = 1'b0;
        bad_next = 1'b0;
        rdata_next = 32'd0;
        if (q_cmd.op[2])
        begin
            if (!q_cmd.is_store)
            begin
                rdata_next = (val & q_cmd.fmask) >> q_cmd.b;
            end
            else
            begin
                nv = (val & ~q_cmd.fmask) | (q_cmd.data & q_cmd.fmask);
                wr = 1'b1;
            end
        end
        else if (!q_cmd.is_store)
        begin
            rdata_next = {31'd0, |(val & bitm)};
            unique case (q_cmd.op)
                OP_CLR_OR:  begin nv = val & ~bitm; wr = 1'b1; end
                OP_SET_XOR: begin nv = val | bitm;  wr = 1'b1; end
                default:    bad_next = 1'b1;
            endcase
        end
        else
        begin
            unique case (q_cmd.op)
                OP_AND:     begin nv = val & q_cmd.data; wr = 1'b1; end
                OP_CLR_OR:  begin nv = val | q_cmd.data; wr = 1'b1; end
                OP_SET_XOR: begin nv = val ^ q_cmd.data; wr = 1'b1; end
                default:    bad_next = 1'b1;
            endcase
        end

        state_next = state_reg;
        clr_next = clr_reg;
        ovalid_next = ovalid_reg && stall;
        idx_next = idx;
        q_pop = 1'b0;
        we = 1'b0;
        waddr = idx_reg;
        wdata = (word & ~(smask << q_cmd.sh)) | ((nv & smask) << q_cmd.sh);
        if (state_reg != ST_WRITE)
        begin
            rdata_next = rdata_reg;
            bad_next = bad_reg;
        end
        unique case (state_reg)
            ST_CLEAR:
            begin
                we = 1'b1;
                waddr = clr_reg;
                wdata = 32'd0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid && !ovalid_next)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                we = wr;
                q_pop = 1'b1;
                ovalid_next = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign valid = ovalid_reg;
    assign read_data = rdata_reg;
    assign bad_opcode = bad_reg;

endmodule

// File: sv/dab_queue.sv
module dab_queue
    import dab_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic not_empty,
    output cmd_t head
);

    cmd_t       ent_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wp_reg] <= push_cmd;
        end
    end

    assign full = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign head = ent_reg[rp_reg];

endmodule

// File: sv/decorated_access_bit_engine.sv
// Decorated bus access engine: each transfer on the input is one load or store at
// base_address + bus_offset, decoded into a bit or bit-field read-modify-write on
// a local memory of 2*REGION_WORDS words. Each access has a read state, then a
// write state on the memory's separate read and write ports and ends before the
// next one starts; a two-entry queue between the decoder and the memory side
// lets inputs be taken while a result is stalled. After reset the memory is
// cleared one word a cycle, all 2*REGION_WORDS words, before the first access
// is carried out. base_address may only be written while the block is idle.
module decorated_access_bit_engine
    import dab_pkg::*;
#(
    parameter int unsigned REGION_WORDS = REGION_WORDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [25:0] bus_offset,
    input  logic [31:0] write_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] read_data,
    output logic        bad_opcode
);

    cmd_t cmd;
    cmd_t head;
    logic accept;
    logic full;
    logic not_empty;
    logic pop;

    dab_front u_front (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .valid_in(in_valid), .command(command), .bus_offset(bus_offset),
        .write_data(write_data), .accept(accept), .q_full(full), .cmd(cmd)
    );

    dab_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(accept), .push_cmd(cmd), .pop(pop),
        .full(full), .not_empty(not_empty), .head(head)
    );

    dab_back #(.REGION_WORDS(REGION_WORDS)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(not_empty), .q_cmd(head), .q_pop(pop),
        .valid(out_valid), .stall(out_stall), .read_data(read_data),
        .bad_opcode(bad_opcode)
    );

    assign in_stall = full;

endmodule

// File: verif/testbench.sv
`default_nettype none

module testbench;
    import dab_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned REGION = REGION_WORDS_DEF;
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STORE = 1'b1;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 400;

    typedef struct {
        logic        store;
        logic [25:0] offset;
        logic [31:0] wdata;
    } access_t;

    typedef struct {
        logic [31:0] rdata;
        logic        bad;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic        command;
    logic [25:0] bus_offset;
    logic [31:0] write_data;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] read_data;
    logic        bad_opcode;

    access_t     pending_accesses[$];
    outcome_t    expected_outcomes[$];
    logic [31:0] shadow_mem[2*REGION];
    logic [31:0] shadow_base;
    int unsigned error_count;
    int unsigned accepted_count;
    int unsigned cycle_count;
    logic        hold_rx;

    decorated_access_bit_engine u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .bus_offset(bus_offset),
        .write_data(write_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .read_data (read_data),
        .bad_opcode(bad_opcode)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // compute the result of one access and update the shadow memory
    function automatic void predict_access(input access_t a);
        logic [31:0] d, smask, phys, word, val, nv, fmask, res;
        logic [2:0]  op;
        int unsigned size, idx, sh, b, w;
        logic        wr, bad;
        outcome_t    o;
        d = shadow_base + {6'b0, a.offset};
        op = d[28:26];
        size = d[0] ? 1 : (d[1] ? 2 : 4);
        smask = (size == 1) ? 32'hFF : ((size == 2) ? 32'hFFFF : 32'hFFFF_FFFF);
        wr = 1'b0;
        bad = 1'b0;
        res = '0;
        nv = '0;
        if (op[2])
        begin
            b = (d & (32'h0380_0000 | ((size - 1) << 26))) >> 23;
            w = (d & (32'h0038_0000 | (((size - 1) & 1) << 22))) >> 19;
            fmask = ((32'd1 << (w + 1)) - 32'd1) << b;
            phys = d & FIELD_PHYS_MASK;
        end
        else
        begin
            b = (d & (32'h00E0_0000 | ((size - 1) << 24))) >> 21;
            fmask = '0;
            phys = d & BIT_PHYS_MASK;
        end
        idx = (phys[30] ? REGION : 0) + ((phys >> 2) % REGION);
        sh = (size == 1) ? 8 * (phys & 3) : ((size == 2) ? 8 * (phys & 2) : 0);
        word = shadow_mem[idx];
        val = (word >> sh) & smask;
        if (op[2])
        begin
            if (a.store == CMD_LOAD)
                res = (val & fmask) >> b;
            else
            begin
                nv = (val & ~fmask) | (a.wdata & fmask);
                wr = 1'b1;
            end
        end
        else if (a.store == CMD_LOAD)
        begin
            res = (val >> b) & 32'd1;
            if (op == OP_CLR_OR)
            begin
                nv = val & ~(32'd1 << b);
                wr = 1'b1;
            end
            else if (op == OP_SET_XOR)
            begin
                nv = val | (32'd1 << b);
                wr = 1'b1;
            end
            else
                bad = 1'b1;
        end
        else
        begin
            wr = 1'b1;
            if (op == OP_AND)
                nv = val & a.wdata;
            else if (op == OP_CLR_OR)
                nv = val | a.wdata;
            else if (op == OP_SET_XOR)
                nv = val ^ a.wdata;
            else
            begin
                wr = 1'b0;
                bad = 1'b1;
            end
        end
        if (wr)
            shadow_mem[idx] = (word & ~(smask << sh)) | ((nv & smask) << sh);
        o.rdata = (a.store == CMD_STORE) ? 32'd0 : res;
        o.bad = bad;
        expected_outcomes.push_back(o);
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin : driver
        int unsigned gap;
        access_t     a;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            command <= 1'b0;
            bus_offset <= '0;
            write_data <= '0;
            gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_access('{command, bus_offset, write_data});
                accepted_count++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap > 0)
                begin
                    gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_accesses.size() > 0)
                begin
                    a = pending_accesses.pop_front();
                    command <= a.store;
                    bus_offset <= a.offset;
                    write_data <= a.wdata;
                    in_valid <= 1'b1;
                    gap = pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin : monitor
        int unsigned stall_left;
        outcome_t    o;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected transfer: read_data=%h bad_opcode=%b",
                                 read_data, bad_opcode);
                end
                else
                begin
                    o = expected_outcomes.pop_front();
                    if (read_data !== o.rdata || bad_opcode !== o.bad)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display({"mismatch: read_data exp %h got %h, ",
                                      "bad_opcode exp %b got %b"},
                                     o.rdata, read_data, o.bad, bad_opcode);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                stall_left = pick_gap();
                out_stall <= hold_rx || (stall_left > 0);
            end
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial
    begin
        hold_rx = 1'b0;
        wait (accepted_count >= 150);
        @(posedge clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic access_t random_access();
        access_t     a;
        int unsigned r;
        a.store = 1'($urandom_range(0, 1));
        a.offset = 26'($urandom);
        // mostly hit a handful of words so that reads see earlier writes
        if ($urandom_range(0, 9) < 7)
            a.offset[11:4] = '0;
        r = $urandom_range(0, 9);
        a.wdata = (r == 0) ? 32'd0 : ((r == 1) ? 32'hFFFF_FFFF : $urandom);
        return a;
    endfunction

    task automatic run_phase(input logic [31:0] base, input int unsigned count);
        wait (pending_accesses.size() == 0 && !in_valid && expected_outcomes.size() == 0);
        repeat (10) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= base;
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow_base = base;
        pending_accesses.push_back('{CMD_LOAD, 26'd0, 32'd0});
        pending_accesses.push_back('{CMD_STORE, 26'h3FF_FFFF, 32'hFFFF_FFFF});
        pending_accesses.push_back('{CMD_STORE, 26'h2AA_A002, $urandom});
        pending_accesses.push_back('{CMD_LOAD, 26'h3FF_FFFF, 32'hFFFF_FFFF});
        repeat (count) pending_accesses.push_back(random_access());
    endtask

    initial
    begin
        logic [31:0] base;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        error_count = 0;
        accepted_count = 0;
        cycle_count = 0;
        shadow_base = BASE_RESET;
        foreach (shadow_mem[i]) shadow_mem[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        run_phase(BASE_RESET, 20);
        for (int op = 0; op < 8; op++)
        begin
            base = $urandom;
            base[28:26] = 3'(op);
            base[11:0] = '0;
            run_phase(base, 40);
        end
        run_phase(32'h0000_0000, 20);
        run_phase(32'hFFFF_FFFF, 20);
        wait (pending_accesses.size() == 0 && !in_valid && expected_outcomes.size() == 0);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
sv/dab_pkg.sv
sv/dab_ram.sv
sv/dab_front.sv
sv/dab_back.sv
sv/dab_queue.sv
sv/decorated_access_bit_engine.sv
verif/testbench.sv
